// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpff_pkg.sv =====
// Package with the shared widths, codes and control structures of the partition allocator.
`default_nettype none
package fpff_pkg;

    localparam int MAX_PARTITIONS_DEF = 16;

    localparam int OP_W     = 1;
    localparam int ID_W     = 8;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int PIDX_W   = 4;

    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd3;

    typedef struct packed {
        logic take;
        logic scan_en;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic miss;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/fpff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/fpff_ctrl.sv =====
// Controller state machine sequencing accept, scan and result transfer.
`default_nettype none
module fpff_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire fpff_pkg::sts_t sts,
    output fpff_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    always_comb
    begin
        slot_free   = !out_valid_reg || !out_stall;
        cmd.take    = (state_reg == S_IDLE) && in_valid;
        cmd.scan_en = (state_reg == S_SCAN);
        cmd.push    = (state_reg == S_HOLD) && slot_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take)
                begin
                    state_next = sts.need_scan ? S_SCAN : S_HOLD;
                end
            end
            S_SCAN:
            begin
                if (sts.hit || sts.miss)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/fpff_datapath.sv =====
// Datapath holding the partition table, the scan pointer and the result registers.
`default_nettype none
module fpff_datapath #(
    parameter int MAX_PARTITIONS = fpff_pkg::MAX_PARTITIONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fpff_pkg::cmd_t                cmd,
    output fpff_pkg::sts_t                     sts,
    input  wire logic [fpff_pkg::OP_W-1:0]     op,
    input  wire logic [fpff_pkg::ID_W-1:0]     item_id,
    input  wire logic [fpff_pkg::SIZE_W-1:0]   size,
    output logic      [fpff_pkg::STATUS_W-1:0] status,
    output logic      [fpff_pkg::ID_W-1:0]     partition_id,
    output logic      [fpff_pkg::PIDX_W-1:0]   partition_index
);

    localparam int CNT_W     = $clog2(MAX_PARTITIONS + 1);
    localparam int IDX_W     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int ENTRY_W   = fpff_pkg::ID_W + fpff_pkg::SIZE_W;
    localparam int IDX_PAD_W = IDX_W + fpff_pkg::PIDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTITIONS);

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [MAX_PARTITIONS-1:0]     busy_reg;
    logic [MAX_PARTITIONS-1:0]     busy_next;
    logic [CNT_W-1:0]              scan_reg;
    logic [CNT_W-1:0]              scan_next;
    logic                          pend_reg;
    logic                          pend_next;
    logic [IDX_W-1:0]              chk_reg;
    logic [IDX_W-1:0]              chk_next;
    logic [fpff_pkg::SIZE_W-1:0]   req_size_reg;
    logic [fpff_pkg::SIZE_W-1:0]   req_size_next;
    logic [fpff_pkg::STATUS_W-1:0] res_status_reg;
    logic [fpff_pkg::STATUS_W-1:0] res_status_next;
    logic [fpff_pkg::ID_W-1:0]     res_id_reg;
    logic [fpff_pkg::ID_W-1:0]     res_id_next;
    logic [IDX_W-1:0]              res_idx_reg;
    logic [IDX_W-1:0]              res_idx_next;
    logic [fpff_pkg::STATUS_W-1:0] out_status_reg;
    logic [fpff_pkg::STATUS_W-1:0] out_status_next;
    logic [fpff_pkg::ID_W-1:0]     out_id_reg;
    logic [fpff_pkg::ID_W-1:0]     out_id_next;
    logic [fpff_pkg::PIDX_W-1:0]   out_idx_reg;
    logic [fpff_pkg::PIDX_W-1:0]   out_idx_next;

    logic                          wr_en;
    logic [ENTRY_W-1:0]            wr_data;
    logic [ENTRY_W-1:0]            rd_data;
    logic [fpff_pkg::ID_W-1:0]     rd_id;
    logic [fpff_pkg::SIZE_W-1:0]   rd_size;
    logic                          issue;
    logic                          fit;
    logic [IDX_PAD_W-1:0]          idx_pad;

    // The table keeps partition id and size side by side in one word.
    fpff_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTITIONS),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[IDX_W-1:0]),
        .wr_data(wr_data),
        .rd_addr(scan_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    always_comb
    begin
        wr_en   = cmd.take && (op == fpff_pkg::OP_LOAD) && (count_reg != CNT_MAX);
        wr_data = {item_id, size};
        rd_id   = rd_data[ENTRY_W-1 -: fpff_pkg::ID_W];
        rd_size = rd_data[fpff_pkg::SIZE_W-1:0];
        issue   = (scan_reg < count_reg);
        fit     = !busy_reg[chk_reg] && (rd_size >= req_size_reg);
        idx_pad = IDX_PAD_W'(res_idx_reg);

        sts.need_scan = (op == fpff_pkg::OP_ALLOC) && (item_id != '0);
        sts.hit       = pend_reg && fit;
        sts.miss      = !pend_reg && !issue;

        count_next      = count_reg;
        busy_next       = busy_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        chk_next        = chk_reg;
        req_size_next   = req_size_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_idx_next    = res_idx_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_idx_next    = out_idx_reg;

        if (cmd.take)
        begin
            if (op == fpff_pkg::OP_LOAD)
            begin
                if (count_reg != CNT_MAX)
                begin
                    busy_next[count_reg[IDX_W-1:0]] = 1'b0;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = fpff_pkg::ST_LOADED;
                    res_id_next     = item_id;
                    res_idx_next    = count_reg[IDX_W-1:0];
                end
                else
                begin
                    res_status_next = fpff_pkg::ST_REJECT;
                    res_id_next     = '0;
                    res_idx_next    = '0;
                end
            end
            else if (item_id == '0)
            begin
                res_status_next = fpff_pkg::ST_REJECT;
                res_id_next     = '0;
                res_idx_next    = '0;
            end
            else
            begin
                req_size_next = size;
                scan_next     = '0;
                pend_next     = 1'b0;
            end
        end

        // One table entry is read per cycle; its data is checked in the next cycle.
        if (cmd.scan_en)
        begin
            if (sts.hit)
            begin
                busy_next[chk_reg] = 1'b1;
                pend_next          = 1'b0;
                res_status_next    = fpff_pkg::ST_GRANTED;
                res_id_next        = rd_id;
                res_idx_next       = chk_reg;
            end
            else
            begin
                if (sts.miss)
                begin
                    res_status_next = fpff_pkg::ST_NOFIT;
                    res_id_next     = '0;
                    res_idx_next    = '0;
                end
                pend_next = issue;
                chk_next  = scan_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
        end

        if (cmd.push)
        begin
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
            out_idx_next    = idx_pad[fpff_pkg::PIDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg        <= chk_next;
        req_size_reg   <= req_size_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_idx_reg    <= out_idx_next;
    end

    assign status          = out_status_reg;
    assign partition_id    = out_id_reg;
    assign partition_index = out_idx_reg;

endmodule
`default_nettype wire

// ===== rtl/fixed_partition_first_fit_top.sv =====
// Top level of the first-fit fixed partition allocator.
// The block takes one item at a time and gives one result per item. A load appends a
// partition to the table, and a rejected item goes straight to its result. An allocate
// request reads the table one entry per cycle from a single RAM read port until the
// first free partition that is large enough, or until the end of the table when nothing
// fits. A finished result waits in an output register until it is transferred.
// Partition id and size sit in a RAM; the free flags are flip-flops.
`default_nettype none
module fixed_partition_first_fit_top #(
    parameter int MAX_PARTITIONS = fpff_pkg::MAX_PARTITIONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [fpff_pkg::OP_W-1:0]     op,
    input  wire logic [fpff_pkg::ID_W-1:0]     item_id,
    input  wire logic [fpff_pkg::SIZE_W-1:0]   size,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [fpff_pkg::STATUS_W-1:0] status,
    output logic      [fpff_pkg::ID_W-1:0]     partition_id,
    output logic      [fpff_pkg::PIDX_W-1:0]   partition_index
);

    fpff_pkg::cmd_t cmd;
    fpff_pkg::sts_t sts;

    fpff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpff_datapath #(
        .MAX_PARTITIONS(MAX_PARTITIONS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .item_id        (item_id),
        .size           (size),
        .status         (status),
        .partition_id   (partition_id),
        .partition_index(partition_index)
    );

endmodule
`default_nettype wire

// ===== rtl/fpff_checker.sv =====
// Port-level checker for the partition allocator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module fpff_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [fpff_pkg::STATUS_W-1:0] status,
    input wire logic [fpff_pkg::ID_W-1:0]     partition_id,
    input wire logic [fpff_pkg::PIDX_W-1:0]   partition_index
);

    // A held result must not vanish before its transfer.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // A held result must keep its payload.
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(status) && $stable(partition_id) && $stable(partition_index), "result changed while stalled")

    // Refused or unfitted items carry no partition.
    `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, out_valid && (status == fpff_pkg::ST_NOFIT || status == fpff_pkg::ST_REJECT), partition_id == '0 && partition_index == '0, "failed result names a partition")

    // Items are worked on one at a time, so a transfer in closes the input.
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while one is at work")

endmodule

bind fixed_partition_first_fit_top fpff_checker u_fpff_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .partition_id   (partition_id),
    .partition_index(partition_index)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the first-fit fixed partition allocator.

typedef struct packed {
    logic [fpff_pkg::STATUS_W-1:0] status;
    logic [fpff_pkg::ID_W-1:0]     partition_id;
    logic [fpff_pkg::PIDX_W-1:0]   partition_index;
} alloc_answer_t;

class alloc_scoreboard;
    logic [fpff_pkg::SIZE_W-1:0] part_size  [fpff_pkg::MAX_PARTITIONS_DEF];
    logic [fpff_pkg::ID_W-1:0]   part_id    [fpff_pkg::MAX_PARTITIONS_DEF];
    logic [fpff_pkg::ID_W-1:0]   part_owner [fpff_pkg::MAX_PARTITIONS_DEF];
    int unsigned                 part_count;
    alloc_answer_t               awaited [$];
    int unsigned                 mismatches;
    int unsigned                 n_loaded;
    int unsigned                 n_granted;
    int unsigned                 n_nofit;
    int unsigned                 n_rejected;

    function new();
        part_count = 0;
        mismatches = 0;
        n_loaded   = 0;
        n_granted  = 0;
        n_nofit    = 0;
        n_rejected = 0;
        for (int k = 0; k < fpff_pkg::MAX_PARTITIONS_DEF; k++) begin
            part_size[k]  = '0;
            part_id[k]    = '0;
            part_owner[k] = '0;
        end
    endfunction

    function void note_request(logic [fpff_pkg::OP_W-1:0] op_code,
                               logic [fpff_pkg::ID_W-1:0] req_id,
                               logic [fpff_pkg::SIZE_W-1:0] req_size);
        alloc_answer_t ans;
        bit            found;
        ans.status          = fpff_pkg::ST_REJECT;
        ans.partition_id    = '0;
        ans.partition_index = '0;
        found               = 1'b0;
        if (op_code == fpff_pkg::OP_LOAD) begin
            if (part_count < fpff_pkg::MAX_PARTITIONS_DEF) begin
                part_id[part_count]    = req_id;
                part_size[part_count]  = req_size;
                part_owner[part_count] = '0;
                ans.status             = fpff_pkg::ST_LOADED;
                ans.partition_id       = req_id;
                ans.partition_index    = 4'(part_count);
                part_count++;
                n_loaded++;
            end else begin
                n_rejected++;
            end
        end else if (req_id == '0) begin
            n_rejected++;
        end else begin
            for (int k = 0; k < part_count && !found; k++) begin
                if (part_owner[k] == '0 && part_size[k] >= req_size) begin
                    part_owner[k]       = req_id;
                    ans.status          = fpff_pkg::ST_GRANTED;
                    ans.partition_id    = part_id[k];
                    ans.partition_index = 4'(k);
                    found               = 1'b1;
                end
            end
            if (found) begin
                n_granted++;
            end else begin
                ans.status = fpff_pkg::ST_NOFIT;
                n_nofit++;
            end
        end
        awaited.push_back(ans);
    endfunction

    function void check_answer(alloc_answer_t got);
        alloc_answer_t want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result: status %0d id %0d index %0d",
                         got.status, got.partition_id, got.partition_index);
            end
            return;
        end
        want = awaited.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch: expected status %0d id %0d index %0d, got status %0d id %0d index %0d",
                         want.status, want.partition_id, want.partition_index,
                         got.status, got.partition_id, got.partition_index);
            end
        end
    endfunction

    function int unsigned outstanding();
        return awaited.size();
    endfunction
endclass

module tb_top;
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 450;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [fpff_pkg::OP_W-1:0]     op = fpff_pkg::OP_LOAD;
    logic [fpff_pkg::ID_W-1:0]     item_id = '0;
    logic [fpff_pkg::SIZE_W-1:0]   size = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [fpff_pkg::STATUS_W-1:0] status;
    logic [fpff_pkg::ID_W-1:0]     partition_id;
    logic [fpff_pkg::PIDX_W-1:0]   partition_index;

    int unsigned     src_idle_pct = 0;
    int unsigned     snk_stall_pct = 0;
    alloc_scoreboard sb = new();

    fixed_partition_first_fit_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .item_id         (item_id),
        .size            (size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .partition_id    (partition_id),
        .partition_index (partition_index)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_answer('{status, partition_id, partition_index});
        end
        out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_request(input logic [fpff_pkg::OP_W-1:0] op_code,
                                input logic [fpff_pkg::ID_W-1:0] req_id,
                                input logic [fpff_pkg::SIZE_W-1:0] req_size);
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        op       <= op_code;
        item_id  <= req_id;
        size     <= req_size;
        do @(posedge clk); while (in_stall);
        sb.note_request(op_code, req_id, req_size);
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    task automatic send_random_request();
        logic [fpff_pkg::ID_W-1:0]   req_id;
        logic [fpff_pkg::SIZE_W-1:0] req_size;
        int unsigned                 pick;
        int unsigned                 slot;
        pick = $urandom_range(3);
        if ($urandom_range(99) == 0) begin
            req_id = 8'($urandom_range(255));
            case (pick)
                0:       req_size = 16'($urandom_range(1023));
                1:       req_size = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                default: req_size = 16'($urandom_range(65535));
            endcase
            send_request(fpff_pkg::OP_LOAD, req_id, req_size);
        end else begin
            req_id = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
            case (pick)
                0: req_size = 16'($urandom_range(255));
                1: req_size = 16'($urandom_range(65535));
                2: begin
                    if (sb.part_count > 0) begin
                        slot     = $urandom_range(sb.part_count - 1);
                        req_size = sb.part_size[slot] + 16'($urandom_range(2)) - 16'd1;
                    end else begin
                        req_size = 16'($urandom_range(65535));
                    end
                end
                default: req_size = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            endcase
            send_request(fpff_pkg::OP_ALLOC, req_id, req_size);
        end
    endtask

    initial begin : stimulus
        int unsigned idle_plan [4];
        int unsigned stall_plan [4];
        idle_plan  = '{0, 71, 0, 13};
        stall_plan = '{0, 0, 71, 13};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_request(fpff_pkg::OP_ALLOC, 8'd5,   16'd0);
        send_request(fpff_pkg::OP_ALLOC, 8'd0,   16'd0);
        send_request(fpff_pkg::OP_LOAD,  8'd0,   16'd0);
        send_request(fpff_pkg::OP_LOAD,  8'hFF,  16'hFFFF);
        send_request(fpff_pkg::OP_LOAD,  8'hFF,  16'd100);
        send_request(fpff_pkg::OP_LOAD,  8'h55,  16'h5555);
        send_request(fpff_pkg::OP_LOAD,  8'hAA,  16'hAAAA);
        send_request(fpff_pkg::OP_ALLOC, 8'hFF,  16'hFFFF);
        send_request(fpff_pkg::OP_ALLOC, 8'd1,   16'd0);
        send_request(fpff_pkg::OP_ALLOC, 8'd0,   16'd100);
        send_request(fpff_pkg::OP_ALLOC, 8'd2,   16'hFFFF);
        send_request(fpff_pkg::OP_ALLOC, 8'd3,   16'd50);
        send_request(fpff_pkg::OP_ALLOC, 8'h80,  16'h5555);
        send_request(fpff_pkg::OP_ALLOC, 8'd4,   16'h5556);
        send_request(fpff_pkg::OP_ALLOC, 8'd4,   16'd1);
        send_request(fpff_pkg::OP_ALLOC, 8'h7F,  16'd0);

        for (int ph = 0; ph < 4; ph++) begin
            drain_pause();
            src_idle_pct  = idle_plan[ph];
            snk_stall_pct = stall_plan[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random_request();
            end
        end

        while (sb.part_count < fpff_pkg::MAX_PARTITIONS_DEF) begin
            send_request(fpff_pkg::OP_LOAD, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        end
        send_request(fpff_pkg::OP_LOAD, 8'h3C, 16'h0F0F);
        send_request(fpff_pkg::OP_ALLOC, 8'hC3, 16'd0);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d loads, %0d grants, %0d no-fit answers and %0d rejections,",
                 sb.n_loaded, sb.n_granted, sb.n_nofit, sb.n_rejected);
        $display("over phases with free flow, sender gaps, receiver stalls and both together.");
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fpff_pkg.sv
rtl/fpff_ram.sv
rtl/fpff_ctrl.sv
rtl/fpff_datapath.sv
rtl/fixed_partition_first_fit_top.sv
rtl/fpff_checker.sv
test/tb_top.sv
